### rtl/core/rpvg_pkg.sv
package rpvg_pkg;

  localparam int COORD_W = 24;
  localparam int IDX_W   = 6;
  localparam int DIFF_W  = 25;
  localparam int RAD_W   = 25;
  localparam int OFF_W   = 27;
  localparam int TRIG_W  = 32;
  localparam int PHASE_W = 32;
  localparam int PROD_W  = 58;
  localparam int SQ_W    = 56;
  localparam int ROOT_W  = 28;
  localparam int PERIM_W = 28;
  localparam int AREA_W  = 46;
  localparam int CROSS_W = 55;
  localparam int STEP_W  = 5;

  localparam logic signed [TRIG_W-1:0] INV_GAIN = 32'sd652032874;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COINCIDE = 2'd1,
    ST_FEW      = 2'd2,
    ST_MANY     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [IDX_W-1:0]          n;
    status_t                   status;
  } job_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic [IDX_W-1:0]          idx;
    logic                      last;
    status_t                   status;
    logic [PERIM_W-1:0]        perim;
    logic [AREA_W-1:0]         area;
  } result_t;

  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/rpvg_fifo.sv
module rpvg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/rpvg_sqrt.sv
module rpvg_sqrt import rpvg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   operand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int SQ_STEPS = SQ_W / 2;
  localparam int CNT_W    = $clog2(SQ_STEPS);
  localparam int REM_W    = ROOT_W + 4;

  logic [SQ_W-1:0]  val;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  assign rem_sh = {rem[REM_W-3:0], val[SQ_W-1:SQ_W-2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(SQ_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= operand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      val <= {val[SQ_W-3:0], 2'b00};
      cnt <= cnt + 1'b1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/core/rpvg_front.sv
module rpvg_front import rpvg_pkg::*; #(
  parameter int MAX_SIDES = 36
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] edge_x,
  input  logic signed [COORD_W-1:0] edge_y,
  input  logic [IDX_W-1:0]          side_count,
  input  logic                      job_take,
  output logic                      job_valid,
  output job_t                      job
);

  job_t job_in;
  logic job_empty;

  always_comb begin
    job_in.cx = center_x;
    job_in.cy = center_y;
    job_in.dx = DIFF_W'(edge_x) - DIFF_W'(center_x);
    job_in.dy = DIFF_W'(edge_y) - DIFF_W'(center_y);
    job_in.n  = side_count;
    if (job_in.dx == '0 && job_in.dy == '0) begin
      job_in.status = ST_COINCIDE;
    end else if (side_count < IDX_W'(3)) begin
      job_in.status = ST_FEW;
    end else if (side_count > IDX_W'(MAX_SIDES)) begin
      job_in.status = ST_MANY;
    end else begin
      job_in.status = ST_OK;
    end
  end

  rpvg_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(2)
  ) u_job_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(job_in),
    .full   (full),
    .rd_en  (job_take),
    .rd_data(job),
    .empty  (job_empty)
  );

  assign job_valid = !job_empty;

endmodule

### rtl/core/rpvg_back.sv
module rpvg_back import rpvg_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_take,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  typedef enum logic [4:0] {
    S_IDLE, S_RSQ_X, S_RSQ_Y, S_RSQ_SUM, S_RSQRT, S_DIV, S_ROT_INIT, S_ROT,
    S_MUL_X, S_MUL_Y, S_OFF_Y, S_VERTEX, S_SIDE_X, S_SIDE_Y, S_SIDE_SUM,
    S_SIDE_SQRT, S_CROSS_A, S_CROSS_B, S_CROSS_D, S_SCALE, S_FINAL, S_EMIT
  } state_t;

  localparam logic signed [PROD_W-1:0] ROUND = 58'sd536870912;
  localparam int DIV_CNT_W = 6;

  state_t state;
  job_t   job_r;
  result_t res_r;

  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]           acc;
  logic [RAD_W-1:0]          r;
  logic [IDX_W-1:0]          div_rem;
  logic [PHASE_W-1:0]        div_q;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic [PHASE_W-1:0]        ph_q;
  logic [IDX_W-1:0]          ph_rem;
  logic [IDX_W-1:0]          k;
  logic signed [TRIG_W-1:0]  cx_r;
  logic signed [TRIG_W-1:0]  cy_r;
  logic signed [TRIG_W-1:0]  cz;
  logic [1:0]                quad;
  logic [STEP_W-1:0]         step;
  logic signed [OFF_W-1:0]   offx;
  logic signed [OFF_W-1:0]   offy;
  logic signed [OFF_W-1:0]   ox0;
  logic signed [OFF_W-1:0]   oy0;
  logic signed [OFF_W-1:0]   ox1;
  logic signed [OFF_W-1:0]   oy1;
  logic [ROOT_W-1:0]         side;
  logic signed [CROSS_W-1:0] cross_a;
  logic signed [CROSS_W-1:0] cross_v;
  logic [60:0]               area_prod;
  logic [33:0]               perim_prod;

  logic                      sq_start;
  logic                      sq_busy;
  logic [ROOT_W-1:0]         sq_root;
  logic [SQ_W-1:0]           sq_operand;

  logic signed [TRIG_W-1:0]  cs;
  logic signed [TRIG_W-1:0]  sn;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [OFF_W:0]     sx;
  logic signed [OFF_W:0]     sy;
  logic [IDX_W:0]            div_sh;
  logic [IDX_W:0]            ph_sum;
  logic signed [OFF_W:0]     vsum_x;
  logic signed [OFF_W:0]     vsum_y;
  logic [CROSS_W-1:0]        acr;
  logic [61:0]               area_rnd;
  logic [61:0]               area_sh;
  logic [TRIG_W-1:0]         atan_ext;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [OFF_W:0] v);
    logic signed [COORD_W-1:0] o;
    if (v > (OFF_W+1)'(8388607)) begin
      o = 24'sh7FFFFF;
    end else if (v < -(OFF_W+1)'(8388608)) begin
      o = 24'sh800000;
    end else begin
      o = v[COORD_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    unique case (quad)
      2'd0: begin cs = cx_r;  sn = cy_r;  end
      2'd1: begin cs = -cy_r; sn = cx_r;  end
      2'd2: begin cs = -cx_r; sn = -cy_r; end
      default: begin cs = cy_r; sn = -cx_r; end
    endcase
  end

  assign rnd        = prod + ROUND;
  assign sx         = (OFF_W+1)'(ox1) - (OFF_W+1)'(ox0);
  assign sy         = (OFF_W+1)'(oy1) - (OFF_W+1)'(oy0);
  assign div_sh     = {div_rem, (div_cnt == '0)};
  assign ph_sum     = {1'b0, ph_rem} + {1'b0, div_rem};
  assign vsum_x     = (OFF_W+1)'(job_r.cx) + (OFF_W+1)'(offx);
  assign vsum_y     = (OFF_W+1)'(job_r.cy) + (OFF_W+1)'(offy);
  assign acr        = cross_v[CROSS_W-1] ? CROSS_W'(-cross_v) : CROSS_W'(cross_v);
  assign area_rnd   = {1'b0, area_prod} + (62'd1 << FRACTION_BITS);
  assign area_sh    = area_rnd >> (FRACTION_BITS + 1);
  assign atan_ext   = {2'b00, atan_turn(step)};
  assign sq_start   = state == S_RSQ_SUM || state == S_SIDE_SUM;
  assign sq_operand = acc + prod[SQ_W-1:0];
  assign job_take   = state == S_IDLE && job_valid;
  assign res_push   = state == S_EMIT && !res_full;
  assign res        = res_r;

  rpvg_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .operand(sq_operand),
    .busy   (sq_busy),
    .root   (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            if (job.status != ST_OK) begin
              res_r <= '{vx: '0, vy: '0, idx: '0, last: 1'b1, status: job.status,
                         perim: '0, area: '0};
              state <= S_EMIT;
            end else begin
              state <= S_RSQ_X;
            end
          end
        end
        S_RSQ_X: begin
          prod  <= job_r.dx * job_r.dx;
          state <= S_RSQ_Y;
        end
        S_RSQ_Y: begin
          acc   <= prod[SQ_W-1:0];
          prod  <= job_r.dy * job_r.dy;
          state <= S_RSQ_SUM;
        end
        S_RSQ_SUM: begin
          state <= S_RSQRT;
        end
        S_RSQRT: begin
          if (!sq_busy) begin
            r       <= sq_root[RAD_W-1:0];
            div_rem <= '0;
            div_q   <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sh >= {1'b0, job_r.n}) begin
            div_rem <= IDX_W'(div_sh - {1'b0, job_r.n});
            div_q   <= {div_q[PHASE_W-2:0], 1'b1};
          end else begin
            div_rem <= div_sh[IDX_W-1:0];
            div_q   <= {div_q[PHASE_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(PHASE_W)) begin
            ph_q   <= '0;
            ph_rem <= job_r.n >> 1;
            k      <= '0;
            state  <= S_ROT_INIT;
          end
        end
        S_ROT_INIT: begin
          cx_r  <= INV_GAIN;
          cy_r  <= '0;
          cz    <= $signed({2'b00, ph_q[PHASE_W-3:0]});
          quad  <= ph_q[PHASE_W-1:PHASE_W-2];
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!cz[TRIG_W-1]) begin
            cx_r <= cx_r - (cy_r >>> step);
            cy_r <= cy_r + (cx_r >>> step);
            cz   <= cz - $signed(atan_ext);
          end else begin
            cx_r <= cx_r + (cy_r >>> step);
            cy_r <= cy_r - (cx_r >>> step);
            cz   <= cz + $signed(atan_ext);
          end
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          prod  <= $signed({1'b0, r}) * cs;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          offx  <= rnd[OFF_W+29:30];
          prod  <= $signed({1'b0, r}) * sn;
          state <= S_OFF_Y;
        end
        S_OFF_Y: begin
          offy  <= rnd[OFF_W+29:30];
          state <= S_VERTEX;
        end
        S_VERTEX: begin
          if (k == '0) begin
            ox0 <= offx;
            oy0 <= offy;
          end
          if (k == IDX_W'(1)) begin
            ox1 <= offx;
            oy1 <= offy;
          end
          res_r.vx     <= sat24(vsum_x);
          res_r.vy     <= sat24(vsum_y);
          res_r.idx    <= k;
          res_r.last   <= k == job_r.n;
          res_r.status <= ST_OK;
          res_r.perim  <= '0;
          res_r.area   <= '0;
          state        <= (k == job_r.n) ? S_SIDE_X : S_EMIT;
        end
        S_SIDE_X: begin
          prod  <= sx * sx;
          state <= S_SIDE_Y;
        end
        S_SIDE_Y: begin
          acc   <= prod[SQ_W-1:0];
          prod  <= sy * sy;
          state <= S_SIDE_SUM;
        end
        S_SIDE_SUM: begin
          state <= S_SIDE_SQRT;
        end
        S_SIDE_SQRT: begin
          if (!sq_busy) begin
            side  <= sq_root;
            state <= S_CROSS_A;
          end
        end
        S_CROSS_A: begin
          prod  <= ox0 * oy1;
          state <= S_CROSS_B;
        end
        S_CROSS_B: begin
          cross_a <= prod[CROSS_W-1:0];
          prod    <= ox1 * oy0;
          state   <= S_CROSS_D;
        end
        S_CROSS_D: begin
          cross_v <= cross_a - prod[CROSS_W-1:0];
          state   <= S_SCALE;
        end
        S_SCALE: begin
          area_prod  <= 61'(job_r.n) * 61'(acr);
          perim_prod <= 34'(job_r.n) * 34'(side);
          state      <= S_FINAL;
        end
        S_FINAL: begin
          res_r.perim <= (perim_prod > 34'(PERIM_MAX)) ? PERIM_MAX
                                                       : perim_prod[PERIM_W-1:0];
          res_r.area  <= (area_sh > 62'(AREA_MAX)) ? AREA_MAX : area_sh[AREA_W-1:0];
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) begin
            if (res_r.last) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              if (ph_sum >= {1'b0, job_r.n}) begin
                ph_rem <= IDX_W'(ph_sum - {1'b0, job_r.n});
                ph_q   <= ph_q + div_q + 1'b1;
              end else begin
                ph_rem <= ph_sum[IDX_W-1:0];
                ph_q   <= ph_q + div_q;
              end
              state <= S_ROT_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/regular_polygon_vertex_generator_unit.sv
// Channel  Direction  Handshake     Fields
// input    in         push / full   center_x, center_y, edge_x, edge_y, side_count
// result   out        pop / empty   vertex_x, vertex_y, vertex_index, last, status,
//                                   perimeter_value, area_value
// A valid item runs a setup (radius square root and the 2*pi/n step division)
// and then a CORDIC rotation per vertex for n + 1 vertices, followed by the
// perimeter and area computation.
// An invalid item's single result goes straight to the emit state once accepted.
// Reset is synchronous and empties both queues. A full result queue stalls the
// back end while the front keeps accepting items into its own queue.
module regular_polygon_vertex_generator_unit import rpvg_pkg::*; #(
  parameter int MAX_SIDES     = 36,
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] edge_x,
  input  logic signed [COORD_W-1:0] edge_y,
  input  logic [IDX_W-1:0]          side_count,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [COORD_W-1:0] vertex_x,
  output logic signed [COORD_W-1:0] vertex_y,
  output logic [IDX_W-1:0]          vertex_index,
  output logic                      last,
  output logic [1:0]                status,
  output logic [PERIM_W-1:0]        perimeter_value,
  output logic [AREA_W-1:0]         area_value
);

  job_t    job;
  logic    job_valid;
  logic    job_take;
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  rpvg_front #(
    .MAX_SIDES(MAX_SIDES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .center_x  (center_x),
    .center_y  (center_y),
    .edge_x    (edge_x),
    .edge_y    (edge_y),
    .side_count(side_count),
    .job_take  (job_take),
    .job_valid (job_valid),
    .job       (job)
  );

  rpvg_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .job_take (job_take),
    .res_push (res_push),
    .res      (res_in),
    .res_full (res_full)
  );

  rpvg_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign vertex_x        = res_out.vx;
  assign vertex_y        = res_out.vy;
  assign vertex_index    = res_out.idx;
  assign last            = res_out.last;
  assign status          = res_out.status;
  assign perimeter_value = res_out.perim;
  assign area_value      = res_out.area;

endmodule
